// ----- src/wpm_pkg.sv -----
`default_nettype none

package wpm_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_DOT  = 8'h2E;

  // broadcast to every cell
  typedef struct packed {
    logic       rearm;
    logic       text;
    logic       wr;
    logic [7:0] sym;
  } cell_ctrl_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic pass;  // star at i carries its active bit to position i+1
    logic adv;   // symbol i consumed the text word, position i+1 becomes active
  } link_t;

endpackage

`default_nettype wire

// ----- src/wpm_cell.sv -----
`default_nettype none

module wpm_cell
  import wpm_pkg::*;
#(
  parameter int unsigned LenW = 7,
  parameter int unsigned Idx  = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire logic [LenW-1:0] len_i,
  input  wire link_t           link_i,
  output link_t                link_o,
  output logic                 end_o
);

  localparam logic [LenW-1:0] IdxL = LenW'(Idx);
  localparam logic             First = (Idx == 0);

  logic [7:0] sym_q, sym_d;
  logic       act_q, act_d;
  logic       in_pat, is_star, hit, closed;

  assign in_pat  = IdxL < len_i;
  assign is_star = sym_q == SYM_STAR;
  assign hit     = (sym_q == SYM_DOT) || (sym_q == ctrl_i.sym);
  // stored pattern has no two stars in a row, so closure spans one hop
  assign closed  = act_q | link_i.pass;

  assign link_o.pass = in_pat & is_star & act_q;
  assign link_o.adv  = in_pat & ~is_star & hit & closed;
  assign end_o       = closed & (IdxL == len_i);

  always_comb begin
    sym_d = sym_q;
    if (ctrl_i.wr && (IdxL == len_i)) begin
      sym_d = ctrl_i.sym;
    end
  end

  always_comb begin
    act_d = act_q;
    if (ctrl_i.rearm) begin
      act_d = First;
    end else if (ctrl_i.text) begin
      act_d = (in_pat & is_star & closed) | link_i.adv;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= First;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/wildcard_pattern_matcher.sv -----
// An end-of-text word gives its result on the master side in the cycle after it is taken.
// Throughput: one word per cycle of any kind; every text word updates all positions at once
// in a row of PATTERN_MAX cells. Input stalls only while a result waits and the master side
// is not ready; a result taken in the same cycle frees the output register for the next one.
// Reset: empty pattern, overflow clear, only position zero active; no clearing pass is needed.
`default_nettype none

module wildcard_pattern_matcher
  import wpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  wire logic [1:0] s_axis_tuser_i,   // [1:0] kind
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [0] matched, [1] overflow, [7:2] zero
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(PATTERN_MAX);

  kind_e      kind;
  logic       fire, full, drop, is_append;
  cell_ctrl_t ctrl;

  logic [LenW-1:0] raw_len_q, raw_len_d;   // symbols appended, stars included
  logic [LenW-1:0] len_q, len_d;           // symbols held, star runs folded to one
  logic            last_star_q, last_star_d;
  logic            ovf_q, ovf_d;
  logic            tail_q, tail_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_data_q, out_data_d;

  link_t              link [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] cell_end;
  logic               tail_closed, tail_end, end_hit;

  assign kind            = kind_e'(s_axis_tuser_i);
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign fire            = s_axis_tvalid_i & s_axis_tready_o;
  assign is_append       = fire & (kind == KIND_APPEND);
  assign full            = raw_len_q == LenMax;
  assign drop            = last_star_q & (s_axis_tdata_i == SYM_STAR);

  assign ctrl.rearm = fire & ((kind == KIND_CLEAR) || (kind == KIND_END));
  assign ctrl.text  = fire & (kind == KIND_TEXT);
  assign ctrl.wr    = is_append & ~full & ~drop;
  assign ctrl.sym   = s_axis_tdata_i;

  assign link[0] = '0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    wpm_cell #(
      .LenW (LenW),
      .Idx  (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .len_i  (len_q),
      .link_i (link[i]),
      .link_o (link[i+1]),
      .end_o  (cell_end[i])
    );
  end

  // last position, after a full store
  assign tail_closed = tail_q | link[PATTERN_MAX].pass;
  assign tail_end    = tail_closed & (len_q == LenMax);
  assign end_hit     = (|cell_end) | tail_end;

  always_comb begin
    tail_d = tail_q;
    if (ctrl.rearm) begin
      tail_d = 1'b0;
    end else if (ctrl.text) begin
      tail_d = link[PATTERN_MAX].adv;
    end
  end

  always_comb begin
    raw_len_d   = raw_len_q;
    len_d       = len_q;
    last_star_d = last_star_q;
    ovf_d       = ovf_q;
    if (fire) begin
      case (kind)
        KIND_CLEAR: begin
          raw_len_d   = '0;
          len_d       = '0;
          last_star_d = 1'b0;
          ovf_d       = 1'b0;
        end
        KIND_APPEND: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            raw_len_d   = raw_len_q + 1'b1;
            last_star_d = s_axis_tdata_i == SYM_STAR;
            if (!drop) begin
              len_d = len_q + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire && (kind == KIND_END)) begin
      out_valid_d = 1'b1;
      out_data_d  = {ovf_q, end_hit & ~ovf_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_data_q};

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_len_q   <= '0;
      len_q       <= '0;
      last_star_q <= 1'b0;
      ovf_q       <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      raw_len_q   <= raw_len_d;
      len_q       <= len_d;
      last_star_q <= last_star_d;
      ovf_q       <= ovf_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
